// ===== rtl/core/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is asserted
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// clocked check with no reset qualifier
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/nta_pkg.sv =====
// shared types, constants and character encoding for the number formatter
// no dependencies
`default_nettype none

package nta_pkg;

  localparam int DEF_MAX_DIGITS = 16;
  localparam int DEF_VALUE_BITS = 64;
  localparam int DEC_BITS       = 32;

  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_ALPHA = 8'h37;  // 'A' - 10
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'

  typedef enum logic [1:0] {
    OP_HEX  = 2'd0,
    OP_UDEC = 2'd1,
    OP_SDEC = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_ALIGN,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    DOP_HOLD,
    DOP_LOAD,
    DOP_DABBLE,
    DOP_SHIFT
  } dop_t;

  typedef struct packed {
    logic valid;
    logic is_sign;
    logic last;
  } emit_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] d8;
    d8 = {4'b0000, d};
    return (d < 4'd10) ? (CH_ZERO + d8) : (CH_ALPHA + d8);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/nta_digit_sr.sv =====
// digit shift register: hex load, bit-serial binary to bcd, nibble shift-out
// depends on nta_pkg
`default_nettype none

module nta_digit_sr
  import nta_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire dop_t                  dop,
  input  wire logic [1:0]            in_op,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic [3:0]                 top_digit,
  output logic                       neg
);

  localparam int DW = 4 * MAX_DIGITS;

  logic [DW-1:0]       dig_r, dig_nxt, adj;
  logic [DEC_BITS-1:0] bin_r, bin_nxt;
  logic                neg_r, neg_nxt;
  logic [DEC_BITS-1:0] word, mag;
  logic                is_neg;

  assign word   = DEC_BITS'(in_value);
  assign is_neg = (op_t'(in_op) == OP_SDEC) && word[DEC_BITS-1];
  assign mag    = is_neg ? (DEC_BITS'(0) - word) : word;

  // add-3 correction on every bcd digit, digits are independent
  always_comb begin
    for (int k = 0; k < MAX_DIGITS; k++) begin
      adj[4*k +: 4] = (dig_r[4*k +: 4] >= 4'd5) ? (dig_r[4*k +: 4] + 4'd3)
                                                : dig_r[4*k +: 4];
    end
  end

  always_comb begin
    dig_nxt = dig_r;
    bin_nxt = bin_r;
    neg_nxt = neg_r;
    unique case (dop)
      DOP_LOAD: begin
        neg_nxt = is_neg;
        if (op_t'(in_op) == OP_HEX) begin
          dig_nxt = DW'(in_value);
          bin_nxt = '0;
        end else begin
          dig_nxt = '0;
          bin_nxt = mag;
        end
      end
      DOP_DABBLE: begin
        dig_nxt = {adj[DW-2:0], bin_r[DEC_BITS-1]};
        bin_nxt = {bin_r[DEC_BITS-2:0], 1'b0};
      end
      DOP_SHIFT: dig_nxt = {dig_r[DW-5:0], 4'b0000};
      default:   dig_nxt = dig_r;
    endcase
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
    bin_r <= bin_nxt;
    neg_r <= neg_nxt;
  end

  assign top_digit = dig_r[DW-1 -: 4];
  assign neg       = neg_r;

endmodule

`default_nettype wire

// ===== rtl/core/nta_seq.sv =====
// sequencer: conversion, alignment and character emission control
// depends on nta_pkg
`default_nettype none

module nta_seq
  import nta_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] in_op,
  input  wire logic [4:0] in_digit_count,
  output logic            busy,
  output dop_t            dop,
  output emit_t           emit
);

  localparam int NW    = $clog2(MAX_DIGITS + 1);
  localparam int CNT_W = $clog2((MAX_DIGITS + 1 > DEC_BITS) ? MAX_DIGITS + 1 : DEC_BITS);
  localparam logic [4:0] MAX_DC = 5'(MAX_DIGITS);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NW-1:0]    ndig_r, ndig_nxt;
  logic             sgn_r, sgn_nxt;
  logic [NW-1:0]    n_sat;
  op_t              op;

  assign op    = op_t'(in_op);
  assign n_sat = (in_digit_count > MAX_DC) ? NW'(MAX_DIGITS) : NW'(in_digit_count);
  assign busy  = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ndig_r  <= '0;
      sgn_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ndig_r  <= ndig_nxt;
      sgn_r   <= sgn_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ndig_nxt  = ndig_r;
    sgn_nxt   = sgn_r;
    dop       = DOP_HOLD;
    emit      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && (op != OP_NONE) && (in_digit_count != 5'd0)) begin
          dop      = DOP_LOAD;
          sgn_nxt  = (op == OP_SDEC);
          ndig_nxt = (op == OP_SDEC) ? (n_sat - NW'(1)) : n_sat;
          if (op == OP_HEX) begin
            state_nxt = ST_ALIGN;
            cnt_nxt   = CNT_W'(MAX_DIGITS) - CNT_W'(n_sat);
          end else begin
            state_nxt = ST_CONV;
            cnt_nxt   = CNT_W'(DEC_BITS - 1);
          end
        end
      end
      ST_CONV: begin
        dop = DOP_DABBLE;
        if (cnt_r == '0) begin
          state_nxt = ST_ALIGN;
          cnt_nxt   = CNT_W'(MAX_DIGITS) - CNT_W'(ndig_r);
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_ALIGN: begin
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(ndig_r);
          state_nxt = sgn_r ? ST_SIGN : ST_EMIT;
        end else begin
          dop     = DOP_SHIFT;
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      ST_SIGN: begin
        emit.valid   = 1'b1;
        emit.is_sign = 1'b1;
        emit.last    = (ndig_r == '0);
        state_nxt    = (ndig_r == '0) ? ST_IDLE : ST_EMIT;
      end
      ST_EMIT: begin
        emit.valid = 1'b1;
        emit.last  = (cnt_r == CNT_W'(1));
        dop        = DOP_SHIFT;
        cnt_nxt    = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/number_to_ascii_formatter.sv =====
// top level of the number to ascii formatter
// depends on nta_pkg, nta_digit_sr, nta_seq and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

// Formats one number per transaction into digit_count ascii characters, at
// most MAX_DIGITS, most significant first, one character per cycle on
// out_character with out_valid high for exactly that cycle and out_last on the
// final one. The receiver cannot stall, so every character must be taken the
// cycle it appears. A transaction is taken when start is high and busy is
// low; op 3 or a zero digit count is taken and produces nothing. Timing is set
// by a 4*MAX_DIGITS bit digit shift register: hex loads it directly, decimal
// fills it with a bit-serial binary to bcd conversion of 32 steps, then it
// shifts one nibble per cycle to align the first wanted digit and one per
// character to emit. Busy goes high after a transaction is taken and stays
// high until the final character is built, so the next one waits for it.
// Each character is registered and appears on the outputs in the cycle after
// the cycle that builds it.
module number_to_ascii_formatter
  import nta_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            in_op,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic [4:0]            in_digit_count,
  output logic                       out_valid,
  output logic [7:0]                 out_character,
  output logic                       out_last
);

  dop_t       dop;
  emit_t      emit;
  logic [3:0] top_digit;
  logic       neg;

  logic       out_valid_r;
  logic       out_last_r;
  logic [7:0] out_character_r, out_character_nxt;

  // control: counts conversion steps, alignment shifts and characters
  nta_seq #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .in_op          (in_op),
    .in_digit_count (in_digit_count),
    .busy           (busy),
    .dop            (dop),
    .emit           (emit)
  );

  // datapath: digit register and the binary word feeding it
  nta_digit_sr #(
    .MAX_DIGITS(MAX_DIGITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_digit_sr (
    .clk       (clk),
    .dop       (dop),
    .in_op     (in_op),
    .in_value  (in_value),
    .top_digit (top_digit),
    .neg       (neg)
  );

  // sign character or the digit currently at the top of the register
  always_comb begin
    if (emit.is_sign) begin
      out_character_nxt = neg ? CH_MINUS : CH_PLUS;
    end else begin
      out_character_nxt = digit_char(top_digit);
    end
  end

  // output register, strobe and last flag cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      out_valid_r <= emit.valid;
      out_last_r  <= emit.valid && emit.last;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_character_r <= out_character_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_last      = out_last_r;
  assign out_character = out_character_r;

  // a transaction that produces characters makes the block busy
  `ASSERT_CLK_RST(a_accept_busy, clk, rst_n,
    (start && !busy && (in_op != OP_NONE) && (in_digit_count != 5'd0)) |=> busy,
    "productive transaction did not start work")

  // the final character of a number is followed by a gap
  `ASSERT_CLK_RST(a_last_gap, clk, rst_n,
    (out_valid && out_last) |=> !out_valid,
    "character directly after the final one")

  // finishing a number always delivers its final character
  `ASSERT_CLK_RST(a_done_last, clk, rst_n,
    $fell(busy) |-> (out_valid && out_last),
    "work ended without a final character")

endmodule

`default_nettype wire

// ===== tb/number_to_ascii_formatter_test.sv =====
// self-checking testbench for number_to_ascii_formatter: hex, unsigned and signed decimal
// formatting, ignored commands, digit count saturation and random traffic with idle gaps
// depends on nta_pkg and the number_to_ascii_formatter rtl
module number_to_ascii_formatter_test
  import nta_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_CHARS    = DEF_MAX_DIGITS;
  // drain wait is longer than the longest busy stretch, so this covers any trailing work
  localparam int DRAIN_CYCLES = DEF_MAX_DIGITS + 48;

  // one expected character of a formatted number
  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } char_beat_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_op;
  logic [DEF_VALUE_BITS-1:0] in_value;
  logic [4:0]                in_digit_count;
  logic                      out_valid;
  logic [7:0]                out_character;
  logic                      out_last;

  // characters still owed by the block, oldest first
  char_beat_t pending_chars[$];
  char_beat_t head_char;
  int         error_count;

  number_to_ascii_formatter #(
    .MAX_DIGITS(DEF_MAX_DIGITS),
    .VALUE_BITS(DEF_VALUE_BITS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_value      (in_value),
    .in_digit_count(in_digit_count),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs or drops characters
  initial begin
    #2ms;
    $display("Some tests failed");
    $finish;
  end

  // works out the characters one accepted command must produce and queues them
  function automatic void predict_chars(op_t op, logic [63:0] value, logic [4:0] count);
    logic [7:0]  text [MAX_CHARS];
    int          n;
    int          pos;
    logic [3:0]  nib;
    logic [31:0] word;
    logic [31:0] rest;
    char_beat_t  beat;
    n = count;
    // unused opcode and zero count produce nothing
    if (op == OP_NONE || n == 0) return;
    // oversize counts clamp to the maximum width
    if (n > MAX_CHARS) n = MAX_CHARS;
    case (op)
      OP_HEX: begin
        for (int i = 0; i < n; i++) begin
          pos = n - 1 - i;
          nib = (pos < 16) ? value[4*pos +: 4] : 4'd0;
          text[i] = (nib < 4'd10) ? CH_ZERO + {4'b0000, nib} : CH_ALPHA + {4'b0000, nib};
        end
      end
      OP_UDEC: begin
        // low 32 bits, zero padded, high digits that do not fit are dropped
        rest = value[31:0];
        for (int i = n - 1; i >= 0; i--) begin
          text[i] = CH_ZERO + 8'(rest % 10);
          rest = rest / 10;
        end
      end
      default: begin
        // sign first, then n-1 magnitude digits; the most negative value wraps to 2^31
        word = value[31:0];
        if (word[31]) begin
          text[0] = CH_MINUS;
          rest = -word;
        end else begin
          text[0] = CH_PLUS;
          rest = word;
        end
        for (int i = n - 1; i >= 1; i--) begin
          text[i] = CH_ZERO + 8'(rest % 10);
          rest = rest / 10;
        end
      end
    endcase
    for (int i = 0; i < n; i++) begin
      beat.character = text[i];
      beat.last      = (i == n - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  // result checker: every strobed character is matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character, expected none, got %h last %b",
                 $time, out_character, out_last);
        error_count++;
      end else begin
        head_char = pending_chars.pop_front();
        if (out_character !== head_char.character) begin
          $display("%0t: character mismatch, expected %h, got %h",
                   $time, head_char.character, out_character);
          error_count++;
        end
        if (out_last !== head_char.last) begin
          $display("%0t: last flag mismatch, expected %b, got %b",
                   $time, head_char.last, out_last);
          error_count++;
        end
      end
    end
  end

  // drives one transaction from a falling edge and holds it until start && !busy
  // start stays high on return so a back-to-back transaction needs no extra edge
  task automatic send_number(op_t op, logic [63:0] value, logic [4:0] count);
    logic taken;
    start          <= 1'b1;
    in_op          <= op;
    in_value       <= value;
    in_digit_count <= count;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      if (!busy) taken = 1'b1;
    end
    predict_chars(op, value, count);
    @(negedge clk);
  endtask

  // sender drops start and idles with junk on the payload ports, n sets the gap length
  task automatic idle_cycles(int n);
    for (int k = 0; k < n; k++) begin
      if (k == 0) start <= 1'b0;
      in_op          <= 2'($urandom);
      in_value       <= {$urandom, $urandom};
      in_digit_count <= 5'($urandom);
      @(negedge clk);
    end
  endtask

  // geometric gap length, pct chance of each further idle cycle
  function automatic int pick_gap(int pct);
    int n;
    n = 0;
    while (n < 24 && $urandom_range(99) < pct) n++;
    return n;
  endfunction

  // stop sending until every owed character has come out, then let the block settle
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic test_hex_directed();
    send_number(OP_HEX, 64'hFFFF_FFFF_FFFF_FFFF, 5'd16);
    send_number(OP_HEX, 64'h0123_4567_89AB_CDEF, 5'd16);
    send_number(OP_HEX, 64'hFEDC_BA98_7654_3210, 5'd1);
    send_number(OP_HEX, 64'h0000_0000_0000_0000, 5'd16);
    send_number(OP_HEX, 64'h0000_0000_0000_00A5, 5'd4);
  endtask

  task automatic test_udec_directed();
    send_number(OP_UDEC, 64'h0000_0000_FFFF_FFFF, 5'd10);
    // upper word must be ignored
    send_number(OP_UDEC, 64'hFFFF_FFFF_0000_0000, 5'd16);
    // high digits dropped
    send_number(OP_UDEC, 64'd1234567, 5'd3);
    send_number(OP_UDEC, 64'd0, 5'd1);
    send_number(OP_UDEC, 64'h1234_5678_FFFF_FFFF, 5'd16);
  endtask

  task automatic test_sdec_directed();
    // most negative value shows its full magnitude
    send_number(OP_SDEC, 64'h0000_0000_8000_0000, 5'd11);
    send_number(OP_SDEC, 64'hFFFF_FFFF_7FFF_FFFF, 5'd11);
    send_number(OP_SDEC, 64'h0000_0000_FFFF_FFFF, 5'd4);
    send_number(OP_SDEC, 64'd0, 5'd16);
    // sign character alone
    send_number(OP_SDEC, 64'h0000_0000_8000_0001, 5'd1);
    send_number(OP_SDEC, 64'd7, 5'd2);
  endtask

  task automatic test_ignored_items();
    send_number(OP_NONE, 64'h0123_4567_89AB_CDEF, 5'd16);
    send_number(OP_UDEC, 64'd99, 5'd0);
    send_number(OP_NONE, 64'd0, 5'd0);
    // must recover and format normally afterwards
    send_number(OP_HEX, 64'h0000_0000_000B_EEF0, 5'd5);
  endtask

  task automatic test_saturation();
    send_number(OP_HEX, 64'hA5A5_5A5A_C3C3_3C3C, 5'd17);
    send_number(OP_UDEC, 64'h0000_0000_DEAD_BEEF, 5'd31);
    send_number(OP_SDEC, 64'h0000_0000_8000_0000, 5'd20);
  endtask

  // sender holds off with nothing outstanding, then resumes back to back
  task automatic test_drain_pause();
    send_number(OP_SDEC, 64'h0000_0000_FFFF_FF85, 5'd6);
    wait_drained();
    send_number(OP_UDEC, 64'd4096, 5'd8);
    send_number(OP_HEX, 64'h8000_0000_0000_0001, 5'd16);
  endtask

  // random transactions, mostly well formed, some ignored or oversize
  task automatic test_random(int idle_pct, int items);
    op_t         op;
    logic [4:0]  count;
    logic [63:0] value;
    for (int k = 0; k < items; k++) begin
      op = ($urandom_range(99) < 10) ? OP_NONE : op_t'($urandom_range(2));
      if ($urandom_range(99) < 85) count = 5'($urandom_range(16, 1));
      else if ($urandom_range(1) == 1) count = 5'd0;
      else count = 5'($urandom_range(31, 17));
      case ($urandom_range(3))
        0: value = {$urandom, $urandom};
        1: value = 64'($urandom_range(999));
        // straddle the 32-bit sign boundary
        2: value = {$urandom, 32'h7FFF_FFF0 + 32'($urandom_range(31))};
        default: value = {$urandom, -32'($urandom_range(1000))};
      endcase
      send_number(op, value, count);
      idle_cycles(pick_gap(idle_pct));
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_op          = OP_HEX;
    in_value       = '0;
    in_digit_count = '0;
    error_count    = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_hex_directed();
    test_udec_directed();
    test_sdec_directed();
    test_ignored_items();
    test_saturation();
    test_drain_pause();
    // no idling, sender idle most of the time, light idling
    test_random(0, 100);
    test_random(73, 100);
    test_random(8, 90);

    wait_drained();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
